>>> rtl/hsc_pkg.sv
// Package for the humidity sensor compensation block: types, constants and
// fixed-point helper functions shared by all pipeline modules. No dependencies.
`timescale 1ns / 1ps
package hsc_pkg;

	localparam int HSC_DIV_STAGES = 32;

	localparam logic [19:0] SKIP_CODE = 20'h80000;
	localparam logic [31:0] HUM_MAX = 32'd419430400;

	localparam logic [2:0] REG_TEMP = 3'd0;
	localparam logic [2:0] REG_PRESS_LOW = 3'd1;
	localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
	localparam logic [2:0] REG_PRESS_NINE = 3'd3;
	localparam logic [2:0] REG_HUM = 3'd4;

	typedef struct packed {
		logic [47:0] temp_coeffs;
		logic [63:0] press_coeffs_low;
		logic [63:0] press_coeffs_high;
		logic [15:0] press_coeff_nine;
		logic [63:0] hum_coeffs;
	} coef_t;

	typedef struct packed {
		logic        ok;
		logic        dbl;
		logic        azero;
		logic [31:0] temp;
		logic [31:0] left;
		logic [31:0] r2;
	} side_t;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		side_t       side;
	} div_in_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx12(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
		return $unsigned($signed(x) >>> n);
	endfunction

endpackage

>>> rtl/hsc_sample_if.sv
// Input channel interface carrying one raw sensor sample per transaction.
// Depends on nothing.
`timescale 1ns / 1ps
interface hsc_sample_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temp;
	logic [19:0] raw_press;
	logic [15:0] raw_hum;
	modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
	modport sink (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

>>> rtl/hsc_result_if.sv
// Output channel interface carrying one compensated result per transaction.
// Depends on nothing.
`timescale 1ns / 1ps
interface hsc_result_if;
	logic        valid;
	logic        ready;
	logic        reading_ok;
	logic [31:0] temp_centideg;
	logic [31:0] press_pascal;
	logic [16:0] hum_scaled;
	modport source (output valid, reading_ok, temp_centideg, press_pascal, hum_scaled,
		input ready);
	modport sink (input valid, reading_ok, temp_centideg, press_pascal, hum_scaled,
		output ready);
endinterface

>>> rtl/hsc_cfg_if.sv
// Configuration write channel interface: register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps
interface hsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/hsc_front.sv
// Front pipeline: temperature, pressure divisor and dividend, and the first
// half of the humidity formula over eleven stages. Depends on hsc_pkg.
`timescale 1ns / 1ps
module hsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [19:0]        raw_temp,
	input  logic [19:0]        raw_press,
	input  logic [15:0]        raw_hum,
	input  hsc_pkg::coef_t     coef,
	output logic               out_valid,
	output hsc_pkg::div_in_t   out_data
);
	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h2, h3, h4, h5, h6;
	logic [31:0] at, ap_w;
	logic [10:0] v_q;

	logic [31:0] ta_s1, d_s1, ap_s1;
	logic [15:0] ah_s1;
	logic        ok_s1;
	logic [31:0] m1_s2, dd_s2, ap_s2;
	logic [15:0] ah_s2;
	logic        ok_s2;
	logic [31:0] v1_s3, m2_s3, ap_s3;
	logic [15:0] ah_s3;
	logic        ok_s3;
	logic [31:0] tf_s4, ap_s4;
	logic [15:0] ah_s4;
	logic        ok_s4;
	logic [31:0] temp_s5, a_s5, q_s5, x_s5, ap_s5;
	logic [15:0] ah_s5;
	logic        ok_s5;
	logic [31:0] sq_s6, a5_s6, ap2_s6, hx5_s6, i1m_s6, i2m_s6, temp_s6, ap_s6;
	logic [15:0] ah_s6;
	logic        ok_s6;
	logic [31:0] bm_s7, mp3_s7, a5_s7, ap2_s7, left_s7, i1_s7, i2_s7, temp_s7, ap_s7;
	logic        ok_s7;
	logic [31:0] b_s8, a2_s8, ri_s8, left_s8, temp_s8, ap_s8;
	logic        ok_s8;
	logic [31:0] am_s9, pn_s9, r_s9, left_s9, temp_s9;
	logic        ok_s9;
	logic [31:0] ad_s10, pm_s10, rm_s10, left_s10, temp_s10;
	logic        ok_s10;
	logic [31:0] tf5, a_c;

	assign t1 = {16'd0, coef.temp_coeffs[15:0]};
	assign t2 = hsc_pkg::sx16(coef.temp_coeffs[31:16]);
	assign t3 = hsc_pkg::sx16(coef.temp_coeffs[47:32]);
	assign p1 = {16'd0, coef.press_coeffs_low[15:0]};
	assign p2 = hsc_pkg::sx16(coef.press_coeffs_low[31:16]);
	assign p3 = hsc_pkg::sx16(coef.press_coeffs_low[47:32]);
	assign p4 = hsc_pkg::sx16(coef.press_coeffs_low[63:48]);
	assign p5 = hsc_pkg::sx16(coef.press_coeffs_high[15:0]);
	assign p6 = hsc_pkg::sx16(coef.press_coeffs_high[31:16]);
	assign h2 = hsc_pkg::sx16(coef.hum_coeffs[23:8]);
	assign h3 = {24'd0, coef.hum_coeffs[31:24]};
	assign h4 = hsc_pkg::sx12(coef.hum_coeffs[43:32]);
	assign h5 = hsc_pkg::sx12(coef.hum_coeffs[55:44]);
	assign h6 = hsc_pkg::sx8(coef.hum_coeffs[63:56]);

	assign at = {12'd0, raw_temp};
	assign ap_w = {12'd0, raw_press};
	assign tf5 = tf_s4 + (tf_s4 << 2);
	assign a_c = hsc_pkg::asr(tf_s4, 5'd1) - 32'd64000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[9:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1 <= (at >> 3) - (t1 << 1);
			d_s1 <= (at >> 4) - t1;
			ap_s1 <= ap_w;
			ah_s1 <= raw_hum;
			ok_s1 <= (raw_temp != hsc_pkg::SKIP_CODE) && (raw_press != hsc_pkg::SKIP_CODE);

			m1_s2 <= ta_s1 * t2;
			dd_s2 <= d_s1 * d_s1;
			ap_s2 <= ap_s1;
			ah_s2 <= ah_s1;
			ok_s2 <= ok_s1;

			v1_s3 <= hsc_pkg::asr(m1_s2, 5'd11);
			m2_s3 <= hsc_pkg::asr(dd_s2, 5'd12) * t3;
			ap_s3 <= ap_s2;
			ah_s3 <= ah_s2;
			ok_s3 <= ok_s2;

			tf_s4 <= v1_s3 + hsc_pkg::asr(m2_s3, 5'd14);
			ap_s4 <= ap_s3;
			ah_s4 <= ah_s3;
			ok_s4 <= ok_s3;

			temp_s5 <= hsc_pkg::asr(tf5 + 32'd128, 5'd8);
			a_s5 <= a_c;
			q_s5 <= hsc_pkg::asr(a_c, 5'd2);
			x_s5 <= tf_s4 - 32'd76800;
			ap_s5 <= ap_s4;
			ah_s5 <= ah_s4;
			ok_s5 <= ok_s4;

			sq_s6 <= q_s5 * q_s5;
			a5_s6 <= a_s5 * p5;
			ap2_s6 <= p2 * a_s5;
			hx5_s6 <= h5 * x_s5;
			i1m_s6 <= x_s5 * h6;
			i2m_s6 <= x_s5 * h3;
			temp_s6 <= temp_s5;
			ap_s6 <= ap_s5;
			ah_s6 <= ah_s5;
			ok_s6 <= ok_s5;

			bm_s7 <= hsc_pkg::asr(sq_s6, 5'd11) * p6;
			mp3_s7 <= p3 * hsc_pkg::asr(sq_s6, 5'd13);
			a5_s7 <= a5_s6;
			ap2_s7 <= ap2_s6;
			left_s7 <= hsc_pkg::asr((({16'd0, ah_s6} << 14) - (h4 << 20) - hx5_s6)
				+ 32'd16384, 5'd15);
			i1_s7 <= hsc_pkg::asr(i1m_s6, 5'd10);
			i2_s7 <= hsc_pkg::asr(i2m_s6, 5'd11) + 32'd32768;
			temp_s7 <= temp_s6;
			ap_s7 <= ap_s6;
			ok_s7 <= ok_s6;

			b_s8 <= hsc_pkg::asr(bm_s7 + (a5_s7 << 1), 5'd2) + (p4 << 16);
			a2_s8 <= hsc_pkg::asr(hsc_pkg::asr(mp3_s7, 5'd3) + hsc_pkg::asr(ap2_s7, 5'd1),
				5'd18);
			ri_s8 <= i1_s7 * i2_s7;
			left_s8 <= left_s7;
			temp_s8 <= temp_s7;
			ap_s8 <= ap_s7;
			ok_s8 <= ok_s7;

			am_s9 <= (32'd32768 + a2_s8) * p1;
			pn_s9 <= (32'd1048576 - ap_s8) - hsc_pkg::asr(b_s8, 5'd12);
			r_s9 <= hsc_pkg::asr(ri_s8, 5'd10) + 32'd2097152;
			left_s9 <= left_s8;
			temp_s9 <= temp_s8;
			ok_s9 <= ok_s8;

			ad_s10 <= hsc_pkg::asr(am_s9, 5'd15);
			pm_s10 <= pn_s9 * 32'd3125;
			rm_s10 <= r_s9 * h2;
			left_s10 <= left_s9;
			temp_s10 <= temp_s9;
			ok_s10 <= ok_s9;

			out_data.num <= pm_s10[31] ? pm_s10 : (pm_s10 << 1);
			out_data.den <= ad_s10;
			out_data.side.dbl <= pm_s10[31];
			out_data.side.azero <= (ad_s10 == 32'd0);
			out_data.side.ok <= ok_s10;
			out_data.side.temp <= temp_s10;
			out_data.side.left <= left_s10;
			out_data.side.r2 <= hsc_pkg::asr(rm_s10 + 32'd8192, 5'd14);
		end
	end

	assign out_valid = v_q[10];
endmodule

>>> rtl/hsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying side data.
// Depends on hsc_pkg.
`timescale 1ns / 1ps
module hsc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  hsc_pkg::div_in_t   in_data,
	output logic               out_valid,
	output logic [31:0]        quo,
	output hsc_pkg::side_t     out_side
);
	logic [31:0]    rem_s  [hsc_pkg::HSC_DIV_STAGES];
	logic [31:0]    num_s  [hsc_pkg::HSC_DIV_STAGES];
	logic [31:0]    den_s  [hsc_pkg::HSC_DIV_STAGES];
	hsc_pkg::side_t side_s [hsc_pkg::HSC_DIV_STAGES];
	logic [31:0]    rem_i  [hsc_pkg::HSC_DIV_STAGES];
	logic [31:0]    num_i  [hsc_pkg::HSC_DIV_STAGES];
	logic [31:0]    den_i  [hsc_pkg::HSC_DIV_STAGES];
	hsc_pkg::side_t side_i [hsc_pkg::HSC_DIV_STAGES];
	logic [32:0]    diff   [hsc_pkg::HSC_DIV_STAGES];
	logic [hsc_pkg::HSC_DIV_STAGES-1:0] v_s;

	always_comb begin
		rem_i[0] = '0;
		num_i[0] = in_data.num;
		den_i[0] = in_data.den;
		side_i[0] = in_data.side;
		for (int k = 1; k < hsc_pkg::HSC_DIV_STAGES; k++) begin
			rem_i[k] = rem_s[k-1];
			num_i[k] = num_s[k-1];
			den_i[k] = den_s[k-1];
			side_i[k] = side_s[k-1];
		end
		for (int k = 0; k < hsc_pkg::HSC_DIV_STAGES; k++) begin
			diff[k] = {rem_i[k], num_i[k][31]} - {1'b0, den_i[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[hsc_pkg::HSC_DIV_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < hsc_pkg::HSC_DIV_STAGES; k++) begin
				if (!diff[k][32]) begin
					rem_s[k] <= diff[k][31:0];
					num_s[k] <= {num_i[k][30:0], 1'b1};
				end else begin
					rem_s[k] <= {rem_i[k][30:0], num_i[k][31]};
					num_s[k] <= {num_i[k][30:0], 1'b0};
				end
				den_s[k] <= den_i[k];
				side_s[k] <= side_i[k];
			end
		end
	end

	assign out_valid = v_s[hsc_pkg::HSC_DIV_STAGES-1];
	assign quo = num_s[hsc_pkg::HSC_DIV_STAGES-1];
	assign out_side = side_s[hsc_pkg::HSC_DIV_STAGES-1];
endmodule

>>> rtl/hsc_back.sv
// Back pipeline: pressure correction terms, humidity finish and clamp, and the
// output register. Depends on hsc_pkg.
`timescale 1ns / 1ps
module hsc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     quo,
	input  hsc_pkg::side_t  side,
	input  hsc_pkg::coef_t  coef,
	output logic            out_valid,
	output logic            reading_ok,
	output logic [31:0]     temp_centideg,
	output logic [31:0]     press_pascal,
	output logic [16:0]     hum_scaled
);
	logic [31:0] p7, p8, p9, h1, p_c, qh, hx_c;
	logic [3:0]  v_q;

	logic [31:0] p_s1, pp_s1, em_s1, hx_s1, temp_s1;
	logic        ok_s1, az_s1;
	logic [31:0] p_s2, cm_s2, em_s2, hx_s2, qq_s2, temp_s2;
	logic        ok_s2, az_s2;
	logic [31:0] p_s3, hx_s3, qm_s3, temp_s3;
	logic        ok_s3;

	assign p7 = hsc_pkg::sx16(coef.press_coeffs_high[47:32]);
	assign p8 = hsc_pkg::sx16(coef.press_coeffs_high[63:48]);
	assign p9 = hsc_pkg::sx16(coef.press_coeff_nine);
	assign h1 = {24'd0, coef.hum_coeffs[7:0]};

	assign p_c = side.azero ? 32'd0 : (side.dbl ? (quo << 1) : quo);
	assign qh = hsc_pkg::asr(hx_s1, 5'd15);
	assign hx_c = hx_s3 - hsc_pkg::asr(qm_s3, 5'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p_c;
			pp_s1 <= (p_c >> 3) * (p_c >> 3);
			em_s1 <= (p_c >> 2) * p8;
			hx_s1 <= side.left * side.r2;
			temp_s1 <= side.temp;
			ok_s1 <= side.ok;
			az_s1 <= side.azero;

			p_s2 <= p_s1;
			cm_s2 <= p9 * (pp_s1 >> 13);
			em_s2 <= em_s1;
			hx_s2 <= hx_s1;
			qq_s2 <= qh * qh;
			temp_s2 <= temp_s1;
			ok_s2 <= ok_s1;
			az_s2 <= az_s1;

			p_s3 <= az_s2 ? 32'd0 : p_s2 + hsc_pkg::asr(hsc_pkg::asr(cm_s2, 5'd12)
				+ hsc_pkg::asr(em_s2, 5'd13) + p7, 5'd4);
			hx_s3 <= hx_s2;
			qm_s3 <= hsc_pkg::asr(qq_s2, 5'd7) * h1;
			temp_s3 <= temp_s2;
			ok_s3 <= ok_s2;

			reading_ok <= ok_s3;
			temp_centideg <= ok_s3 ? temp_s3 : 32'd0;
			press_pascal <= ok_s3 ? p_s3 : 32'd0;
			if (!ok_s3 || hx_c[31]) begin
				hum_scaled <= '0;
			end else if (hx_c > hsc_pkg::HUM_MAX) begin
				hum_scaled <= hsc_pkg::HUM_MAX[28:12];
			end else begin
				hum_scaled <= hx_c[28:12];
			end
		end
	end

	assign out_valid = v_q[3];
endmodule

>>> rtl/humidity_sensor_compensation_top.sv
// An accepted sample passes 11 front stages, 32 divider stages and 4 back
// stages; throughput is one sample per cycle while the output is not stalled.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears all valid bits and the calibration registers to zero.
// Top level; depends on hsc_pkg, the channel interfaces and hsc_front/div/back.
`timescale 1ns / 1ps
module humidity_sensor_compensation_top (
	input  logic          clk,
	input  logic          arst_n,
	hsc_sample_if.sink    sample,
	hsc_result_if.source  result,
	hsc_cfg_if.sink       cfg
);
	hsc_pkg::coef_t   coef_q;
	hsc_pkg::div_in_t front_data;
	hsc_pkg::side_t   div_side;
	logic             en, front_valid, div_valid;
	logic [31:0]      quo;

	assign en = !result.valid || result.ready;
	assign sample.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				hsc_pkg::REG_TEMP: coef_q.temp_coeffs <= cfg.data[47:0];
				hsc_pkg::REG_PRESS_LOW: coef_q.press_coeffs_low <= cfg.data;
				hsc_pkg::REG_PRESS_HIGH: coef_q.press_coeffs_high <= cfg.data;
				hsc_pkg::REG_PRESS_NINE: coef_q.press_coeff_nine <= cfg.data[15:0];
				hsc_pkg::REG_HUM: coef_q.hum_coeffs <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	hsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sample.valid),
		.raw_temp  (sample.raw_temp),
		.raw_press (sample.raw_press),
		.raw_hum   (sample.raw_hum),
		.coef      (coef_q),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	hsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_data   (front_data),
		.out_valid (div_valid),
		.quo       (quo),
		.out_side  (div_side)
	);

	hsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (div_valid),
		.quo           (quo),
		.side          (div_side),
		.coef          (coef_q),
		.out_valid     (result.valid),
		.reading_ok    (result.reading_ok),
		.temp_centideg (result.temp_centideg),
		.press_pascal  (result.press_pascal),
		.hum_scaled    (result.hum_scaled)
	);
endmodule
